/* hdl/rpb_pkg.sv */
// Shared constants, types and the divide-by-255 helper for the pixel blender.
package rpb_pkg;

	localparam int NUM_STAGES = 5;

	localparam logic [1:0] MODE_NORMAL   = 2'd0;
	localparam logic [1:0] MODE_ADD      = 2'd1;
	localparam logic [1:0] MODE_MULTIPLY = 2'd2;

	localparam logic [7:0] CFG_IDX_MODE    = 8'd0;
	localparam logic [7:0] CFG_IDX_OPACITY = 8'd1;

	localparam logic [7:0] FULL_ALPHA = 8'hFF;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} stage_ctl_t;

	// floor(x / 255) for x up to 255*255
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [15:0] t;
		t = x + {8'd0, x[15:8]} + 16'd1;
		return t[15:8];
	endfunction

endpackage

/* hdl/rpb_pipe_ctrl.sv */
// Valid and load-enable chain for the blend pipeline, with bubble collapsing.
module rpb_pipe_ctrl
	import rpb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output stage_ctl_t ctl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	// a stage loads when empty or when the stage after it moves
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[NUM_STAGES-1];
	assign ctl.en    = en;
	assign ctl.vld   = vld_q;

endmodule

/* hdl/rpb_chan.sv */
// One color channel of the blend datapath, stages two through five.
module rpb_chan
	import rpb_pkg::*;
(
	input  logic       clk,
	input  stage_ctl_t ctl,
	input  logic [1:0] mode,
	input  logic [7:0] d_s1,
	input  logic [7:0] s_s1,
	input  logic [7:0] a_s3,
	output logic [7:0] res_s5
);

	logic [7:0]  d_s2, s_s2;
	logic [15:0] ds_s2;
	logic [7:0]  d_s3, s_s3, m_s3;
	logic [7:0]  d_s4;
	logic [15:0] pn_s4, psa_s4, pm_s4;
	logic [15:0] sel_prod;
	logic [7:0]  q;
	logic [8:0]  add_sum;
	logic [7:0]  res_next;

	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			d_s2  <= d_s1;
			s_s2  <= s_s1;
			ds_s2 <= {8'd0, d_s1} * {8'd0, s_s1};
		end
		if (ctl.en[2]) begin
			d_s3 <= d_s2;
			s_s3 <= s_s2;
			m_s3 <= div255(ds_s2);
		end
		if (ctl.en[3]) begin
			d_s4   <= d_s3;
			psa_s4 <= {8'd0, s_s3} * {8'd0, a_s3};
			pn_s4  <= ({8'd0, s_s3} * {8'd0, a_s3}) +
				({8'd0, d_s3} * {8'd0, FULL_ALPHA - a_s3});
			pm_s4  <= {8'd0, d_s3 - m_s3} * {8'd0, a_s3};
		end
		if (ctl.en[4]) begin
			res_s5 <= res_next;
		end
	end

	// pick the product first so one divider serves every mode
	always_comb begin
		unique case (mode)
			MODE_ADD:      sel_prod = psa_s4;
			MODE_MULTIPLY: sel_prod = pm_s4;
			default:       sel_prod = pn_s4;
		endcase
		q       = div255(sel_prod);
		add_sum = {1'b0, d_s4} + {1'b0, q};
		unique case (mode)
			MODE_ADD:      res_next = add_sum[8] ? FULL_ALPHA : add_sum[7:0];
			MODE_MULTIPLY: res_next = d_s4 - q;
			default:       res_next = q;
		endcase
	end

endmodule

/* hdl/rgba_pixel_blend.sv */
// Top level of the RGBA8888 pixel blender: registers, alpha path and output.
//
// Blends one source pixel onto one destination pixel in normal, add or multiply
// mode, scaled by the layer opacity. The datapath is a five-stage pipeline:
// a request taken at the input is registered in stage one, moves through stages
// two to five and is then presented on the output, and one pixel pair is taken
// every cycle while the output side keeps up. Each
// stage holds when the stage after it is full and stalled, so empty stages
// still fill while a result waits. Mode and opacity are written on the
// configuration channel (index 0 mode, index 1 opacity, others ignored) and
// must only change while no request is in flight. No clearing pass after reset.
module rgba_pixel_blend
	import rpb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [31:0] dest_pixel, [63:32] source_pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] blended_pixel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	stage_ctl_t ctl;

	logic [1:0]  mode_q;
	logic [7:0]  opacity_q;

	logic [31:0] dst_s1;
	logic [31:8] src_s1;
	logic [15:0] aprod_s1;
	logic [31:0] dst_s2;
	logic [7:0]  a_s2;
	logic [31:0] dst_s3;
	logic [7:0]  a_s3;
	logic [31:0] dst_s4;
	logic [7:0]  a_s4;
	logic [15:0] pal_s4;
	logic [31:0] px_s5;
	logic [7:0]  a_s5;
	logic        azero_s5;
	logic [7:0]  res_r, res_g, res_b;
	logic [7:0]  alpha_next;
	logic [7:0]  dA4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_NORMAL;
			opacity_q <= FULL_ALPHA;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_IDX_MODE)    mode_q    <= cfg_data[1:0];
			if (cfg_index == CFG_IDX_OPACITY) opacity_q <= cfg_data;
		end
	end

	rpb_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			dst_s1   <= s_tdata[31:0];
			src_s1   <= s_tdata[63:40];
			aprod_s1 <= {8'd0, s_tdata[39:32]} * {8'd0, opacity_q};
		end
		if (ctl.en[1]) begin
			dst_s2 <= dst_s1;
			a_s2   <= div255(aprod_s1);
		end
		if (ctl.en[2]) begin
			dst_s3 <= dst_s2;
			a_s3   <= a_s2;
		end
		if (ctl.en[3]) begin
			dst_s4 <= dst_s3;
			a_s4   <= a_s3;
			pal_s4 <= {8'd0, dst_s3[7:0]} * {8'd0, FULL_ALPHA - a_s3};
		end
		if (ctl.en[4]) begin
			a_s5     <= a_s4;
			azero_s5 <= (a_s4 == 8'd0);
			px_s5    <= (a_s4 == 8'd0) ? dst_s4 : 32'd0;
		end
	end

	rpb_chan u_chan_r (
		.clk (clk), .ctl (ctl), .mode (mode_q),
		.d_s1 (dst_s1[31:24]), .s_s1 (src_s1[31:24]), .a_s3 (a_s3), .res_s5 (res_r)
	);

	rpb_chan u_chan_g (
		.clk (clk), .ctl (ctl), .mode (mode_q),
		.d_s1 (dst_s1[23:16]), .s_s1 (src_s1[23:16]), .a_s3 (a_s3), .res_s5 (res_g)
	);

	rpb_chan u_chan_b (
		.clk (clk), .ctl (ctl), .mode (mode_q),
		.d_s1 (dst_s1[15:8]), .s_s1 (src_s1[15:8]), .a_s3 (a_s3), .res_s5 (res_b)
	);

	// output alpha is computed in stage four's slot and registered with the colors
	logic [7:0] alpha_s5;

	assign dA4 = dst_s4[7:0];

	always_comb begin
		unique case (mode_q)
			MODE_ADD, MODE_MULTIPLY: alpha_next = (dA4 > a_s4) ? dA4 : a_s4;
			default:                 alpha_next = a_s4 + div255(pal_s4);
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en[4]) alpha_s5 <= alpha_next;
	end

	// zero alpha passes the destination through untouched
	assign m_tdata = azero_s5 ? px_s5 : {res_r, res_g, res_b, alpha_s5};

`ifndef SYNTH
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&ctl.vld) && !m_tready) |-> !s_tready)
		else $error("input taken while every stage is full and stalled");

	a_alpha_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.vld[1] |-> (a_s2 <= opacity_q))
		else $error("effective alpha above layer opacity");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ctl.vld[0])
		else $error("accepted request lost at first stage");

	a_out_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !azero_s5) |-> (m_tdata[7:0] >= a_s5))
		else $error("blended alpha below effective alpha");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld[NUM_STAGES-1] && !m_tready) |=> ctl.vld[NUM_STAGES-1])
		else $error("stalled result dropped from last stage");
`endif

endmodule
